>>> rtl/rtv_pkg.sv
// Shared types and constants of the capture-to-command-stream converter.
`default_nettype none
package rtv_pkg;

  // One capture record as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] record_data;
    logic [7:0] record_register;
    logic       is_final;
  } record_t;

  // One stream command as it leaves on the output channel.
  typedef struct packed {
    logic [1:0]  command_kind;
    logic [7:0]  command_opcode;
    logic [7:0]  write_register;
    logic [7:0]  write_value;
    logic [15:0] delay_samples;
    logic [31:0] total_samples;
    logic        dual_chip;
    logic        loop_flag;
    logic        delay_overflow;
    logic        run_end;
  } command_t;

  // Command kinds.
  localparam logic [1:0] KIND_DELAY = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Output opcodes.
  localparam logic [7:0] OP_DELAY       = 8'h61;
  localparam logic [7:0] OP_WRITE_CHIP0 = 8'h5A;
  localparam logic [7:0] OP_WRITE_CHIP1 = 8'hAA;
  localparam logic [7:0] OP_END         = 8'h66;

  // Capture register numbers with special meaning.
  localparam logic [7:0] REC_REG_DELAY   = 8'h00;
  localparam logic [7:0] REC_REG_CONTROL = 8'h02;

  // Control record types.
  localparam logic [7:0] CTL_CLOCK = 8'd0;
  localparam logic [7:0] CTL_CHIP0 = 8'd1;
  localparam logic [7:0] CTL_CHIP1 = 8'd2;

  // Tick to sample time conversion: (tick * 4410 + 59659) / 119318.
  localparam logic [12:0] TICK_SCALE = 13'd4410;
  localparam logic [15:0] ROUND_BIAS = 16'd59659;
  localparam logic [17:0] DIVISOR    = 18'd119318;
  localparam logic [15:0] CHUNK_MAX  = 16'hFFFF;

  // Division by reciprocal multiplication on a 45-bit numerator. The top 32
  // numerator bits times floor(2^48 / 119318), shifted down by 35, give a
  // quotient that is exact or one short; a remainder check adds the one.
  localparam int          DIV_NUM_W  = 45;
  localparam logic [31:0] DIV_RECIP  = 32'd2359031970;
  localparam int          DIV_STEPS  = 3;
  localparam int          DIV_STEP_W = $clog2(DIV_STEPS);

  // Division steps: multiply, estimate with remainder, correction.
  localparam logic [DIV_STEP_W-1:0] DIV_MUL = DIV_STEP_W'(0);
  localparam logic [DIV_STEP_W-1:0] DIV_EST = DIV_STEP_W'(1);
  localparam logic [DIV_STEP_W-1:0] DIV_FIX = DIV_STEP_W'(2);

  // Configuration register map.
  localparam int         APB_ADDR_W        = 3;
  localparam logic       CFG_CLOCK_DIVIDER = 1'b0;
  localparam logic       CFG_LOOP_ENABLE   = 1'b1;

  // Classes of a captured record.
  typedef enum logic [1:0] {
    REC_CLOCK_WORD,
    REC_DELAY,
    REC_CONTROL,
    REC_WRITE
  } rec_class_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIVIDE,
    S_DIFF,
    S_DELAY,
    S_WRITE,
    S_END
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
    logic load;
    logic div_step;
    logic diff;
    logic emit_delay;
    logic emit_write;
    logic emit_end;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    rec_class_t rec_class;
    logic       is_final;
    logic       div_last;
    logic       left_zero;
    logic       chunks_full;
    logic       emit_ok;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/opl_raw_to_vgm_command_stream.sv
// Top level of the raw capture record to stream command converter.
//
// Each record beat turns into zero or more command beats. Delay, control and
// clock-word records are captured and decoded. A chip write record is captured,
// decoded, divided to its sample time, differenced against the emitted samples,
// sent as up to MAX_DELAY_CHUNKS delay chunks and then written; the division
// steps are a reciprocal multiply, an estimate with its remainder, and a
// one-step correction. A final record of any kind also emits an end command.
// One record is in flight at a time; a new record beat is taken while the last
// command beat still waits in the output register. Output stalls hold emission.
// Registers: 0x0 initial clock divider (also loads the live divider),
// 0x4 loop enable. Write them only while the block is idle.
`default_nettype none
module opl_raw_to_vgm_command_stream #(
  parameter int MAX_DELAY_CHUNKS = 62
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rtv_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           record_valid,
  output logic                           record_ready,
  input  rtv_pkg::record_t               record,
  output logic                           command_valid,
  input  logic                           command_ready,
  output rtv_pkg::command_t              command
);
  import rtv_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  // Sequencer.
  rtv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // State, arithmetic and output register.
  rtv_datapath #(
    .MAX_DELAY_CHUNKS (MAX_DELAY_CHUNKS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .rec_item      (record),
    .cmd           (cmd),
    .status        (status),
    .command_valid (command_valid),
    .command_ready (command_ready),
    .command       (command)
  );

endmodule
`default_nettype wire

>>> rtl/rtv_ctrl.sv
// Controller state machine that sequences one record through the datapath.
`default_nettype none
module rtv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               record_valid,
  output logic               record_ready,
  input  rtv_pkg::dp_status_t status,
  output rtv_pkg::ctrl_cmd_t  cmd
);
  import rtv_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    record_ready = 1'b0;
    case (state)
      S_IDLE: begin
        record_ready = 1'b1;
        if (record_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.rec_class == REC_WRITE) begin
          cmd.load   = 1'b1;
          state_next = S_DIVIDE;
        end else begin
          cmd.apply  = 1'b1;
          state_next = status.is_final ? S_END : S_IDLE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_DELAY;
      end
      S_DELAY: begin
        // Chunks go out until the gap is covered or the chunk budget is spent.
        if (status.left_zero || status.chunks_full) begin
          state_next = S_WRITE;
        end else if (status.emit_ok) begin
          cmd.emit_delay = 1'b1;
        end
      end
      S_WRITE: begin
        if (status.emit_ok) begin
          cmd.emit_write = 1'b1;
          state_next     = status.is_final ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (status.emit_ok) begin
          cmd.emit_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/rtv_datapath.sv
// Datapath: converter state, configuration registers, divider, output register.
`default_nettype none
module rtv_datapath #(
  parameter int MAX_DELAY_CHUNKS = 62
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rtv_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  input  rtv_pkg::record_t                   rec_item,
  input  rtv_pkg::ctrl_cmd_t                 cmd,
  output rtv_pkg::dp_status_t                status,
  output logic                               command_valid,
  input  logic                               command_ready,
  output rtv_pkg::command_t                  command
);
  import rtv_pkg::*;

  localparam int                  CHUNK_W     = $clog2(MAX_DELAY_CHUNKS + 1);
  localparam logic [CHUNK_W-1:0]  CHUNK_LIMIT = CHUNK_W'(MAX_DELAY_CHUNKS);
  localparam logic [31:0]         OVF_LIMIT   =
    32'(MAX_DELAY_CHUNKS) * {16'd0, CHUNK_MAX};

  // Configuration and converter state.
  logic [15:0] initial_clock_divider;
  logic        loop_enable;
  logic [15:0] clock_divider;
  logic [31:0] tick_count;
  logic [31:0] emitted_samples;
  logic        chip_select;
  logic        dual_seen;
  logic        await_clock_word;

  // Per-record working registers.
  record_t               rec;
  logic [DIV_NUM_W-1:0]  num;
  logic [63:0]           prod;
  logic [17:0]           rem;
  logic [31:0]           quo;
  logic [DIV_STEP_W-1:0] div_cnt;
  logic [31:0]           left;
  logic [CHUNK_W-1:0]    chunk_cnt;
  logic                  ovf;

  logic                  cfg_we;
  logic                  cfg_idx;
  rec_class_t            rec_class;
  logic [23:0]           tick_inc;
  logic [44:0]           tick_scaled;
  logic [DIV_NUM_W-1:0]  num_load;
  logic [63:0]           recip_prod;
  logic [28:0]           quo_est;
  logic [DIV_NUM_W-1:0]  rem_full;
  logic [31:0]           gap;
  logic [15:0]           chunk;
  logic                  emit;
  command_t              command_next;

  // Register port decode; a write lands in the access cycle.
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_comb begin
    case (cfg_idx)
      CFG_CLOCK_DIVIDER: prdata = {16'd0, initial_clock_divider};
      CFG_LOOP_ENABLE:   prdata = {31'd0, loop_enable};
      default:           prdata = '0;
    endcase
  end

  // Record classification.
  always_comb begin
    if (await_clock_word) begin
      rec_class = REC_CLOCK_WORD;
    end else if (rec.record_register == REC_REG_DELAY) begin
      rec_class = REC_DELAY;
    end else if (rec.record_register == REC_REG_CONTROL) begin
      rec_class = REC_CONTROL;
    end else begin
      rec_class = REC_WRITE;
    end
  end

  assign status.rec_class   = rec_class;
  assign status.is_final    = rec.is_final;
  assign status.div_last    = (div_cnt == DIV_FIX);
  assign status.left_zero   = (left == 32'd0);
  assign status.chunks_full = (chunk_cnt == CHUNK_LIMIT);
  assign status.emit_ok     = !command_valid || command_ready;

  // Tick arithmetic.
  assign tick_inc    = {16'd0, rec.record_data} * {8'd0, clock_divider};
  assign tick_scaled = {13'd0, tick_count} * {32'd0, TICK_SCALE};
  assign num_load    = tick_scaled + {29'd0, ROUND_BIAS};

  // Sample time division: the reciprocal product of the top numerator bits
  // gives an estimate at most one short, and the remainder tells which.
  assign recip_prod = {32'd0, num[DIV_NUM_W-1:DIV_NUM_W-32]} * {32'd0, DIV_RECIP};
  assign quo_est    = prod[63:35];
  assign rem_full   = num - ({16'd0, quo_est} * {27'd0, DIVISOR});

  // Gap between the new sample time and what has been emitted.
  assign gap   = quo - emitted_samples;
  assign chunk = (left > {16'd0, CHUNK_MAX}) ? CHUNK_MAX : left[15:0];

  // Converter state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_clock_divider <= '0;
      loop_enable           <= 1'b0;
      clock_divider         <= '0;
      tick_count            <= '0;
      emitted_samples       <= '0;
      chip_select           <= 1'b0;
      dual_seen             <= 1'b0;
      await_clock_word      <= 1'b0;
    end else begin
      if (cmd.apply) begin
        case (rec_class)
          REC_CLOCK_WORD: begin
            clock_divider    <= {rec.record_register, rec.record_data};
            await_clock_word <= 1'b0;
          end
          REC_DELAY: begin
            tick_count <= tick_count + {8'd0, tick_inc};
          end
          REC_CONTROL: begin
            case (rec.record_data)
              CTL_CLOCK: await_clock_word <= 1'b1;
              CTL_CHIP0: chip_select <= 1'b0;
              CTL_CHIP1: begin
                chip_select <= 1'b1;
                dual_seen   <= 1'b1;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      if (cmd.diff && (emitted_samples < quo)) begin
        emitted_samples <= quo;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CLOCK_DIVIDER: begin
            initial_clock_divider <= pwdata[15:0];
            clock_divider         <= pwdata[15:0];
          end
          CFG_LOOP_ENABLE: loop_enable <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Per-record working registers: capture, divide, chunking.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rec <= rec_item;
      ovf <= 1'b0;
    end
    if (cmd.load) begin
      num     <= num_load;
      div_cnt <= DIV_MUL;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      case (div_cnt)
        DIV_MUL: prod <= recip_prod;
        DIV_EST: begin
          quo <= {3'd0, quo_est};
          rem <= rem_full[17:0];
        end
        default: begin
          if (rem >= DIVISOR) begin
            quo <= quo + 32'd1;
          end
        end
      endcase
    end
    if (cmd.diff) begin
      chunk_cnt <= '0;
      if (emitted_samples < quo) begin
        left <= gap;
        ovf  <= (gap > OVF_LIMIT);
      end else begin
        left <= '0;
      end
    end else if (cmd.emit_delay) begin
      left      <= left - {16'd0, chunk};
      chunk_cnt <= chunk_cnt + 1'b1;
    end
  end

  // Next output beat.
  always_comb begin
    command_next                = '0;
    command_next.delay_overflow = ovf;
    if (cmd.emit_delay) begin
      command_next.command_kind   = KIND_DELAY;
      command_next.command_opcode = OP_DELAY;
      command_next.delay_samples  = chunk;
    end else if (cmd.emit_write) begin
      command_next.command_kind   = KIND_WRITE;
      command_next.command_opcode = chip_select ? OP_WRITE_CHIP1 : OP_WRITE_CHIP0;
      command_next.write_register = rec.record_register;
      command_next.write_value    = rec.record_data;
      command_next.run_end        = !rec.is_final;
    end else begin
      command_next.command_kind   = KIND_END;
      command_next.command_opcode = OP_END;
      command_next.total_samples  = emitted_samples;
      command_next.dual_chip      = dual_seen;
      command_next.loop_flag      = loop_enable;
      command_next.run_end        = 1'b1;
    end
  end

  assign emit = cmd.emit_delay || cmd.emit_write || cmd.emit_end;

  // Output register: holds a beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      command_valid <= 1'b0;
    end else if (emit) begin
      command_valid <= 1'b1;
    end else if (command_ready) begin
      command_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      command <= command_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rtv_checker.sv
// Port-level checks of the converter's command stream, bound to the top level.
`default_nettype none
module rtv_checker (
  input logic              clk,
  input logic              rst,
  input logic              command_valid,
  input logic              command_ready,
  input rtv_pkg::command_t command
);
  import rtv_pkg::*;

  // An end command closes the record and carries its opcode.
  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    command_valid && (command.command_kind == KIND_END)
    |-> (command.command_opcode == OP_END) && command.run_end)
    else $error("end beat malformed");

  // A delay chunk carries its opcode, is never empty and does not end the run.
  a_delay_beat: assert property (@(posedge clk) disable iff (rst)
    command_valid && (command.command_kind == KIND_DELAY)
    |-> (command.command_opcode == OP_DELAY) && !command.run_end &&
        (command.delay_samples != 16'd0))
    else $error("delay beat malformed");

  // A write carries one of the two chip opcodes and no delay or total.
  a_write_beat: assert property (@(posedge clk) disable iff (rst)
    command_valid && (command.command_kind == KIND_WRITE)
    |-> ((command.command_opcode == OP_WRITE_CHIP0) ||
         (command.command_opcode == OP_WRITE_CHIP1)) &&
        (command.delay_samples == 16'd0) && (command.total_samples == 32'd0))
    else $error("write beat malformed");

  // A stalled beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    command_valid && !command_ready |=> command_valid && $stable(command))
    else $error("command beat changed while stalled");

endmodule

bind opl_raw_to_vgm_command_stream rtv_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .command_valid (command_valid),
  .command_ready (command_ready),
  .command       (command)
);
`default_nettype wire
